// ----- hdl/mtrq_pkg.sv -----
package mtrq_pkg;

    typedef logic signed [11:0] exp_t;

    typedef enum logic [1:0]
    {
        FMT_U8,
        FMT_S8,
        FMT_FP32,
        FMT_BF16
    } fmt_t;

    localparam logic [1:0]  REG_SCALE    = 2'd0;
    localparam logic [1:0]  REG_OFFSET   = 2'd1;
    localparam logic [1:0]  REG_FORMAT   = 2'd2;
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;

    typedef struct packed
    {
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } elem_tag_t;

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                pos = 6'(i);
            end
        end
        return 6'd63 - pos;
    endfunction

    function automatic logic [63:0] shift_sticky(input logic [63:0] v, input exp_t d);
        logic [63:0] mask;
        mask = (64'd1 << d[5:0]) - 64'd1;
        if (d <= 12'sd0)
        begin
            return v;
        end
        else if (d >= 12'sd64)
        begin
            return {63'd0, |v};
        end
        return (v >> d[5:0]) | {63'd0, |(v & mask)};
    endfunction

    // m normalised with bit 63 set, value m * 2^e
    function automatic logic [31:0] round_pack(input logic s, input logic [63:0] m,
                                               input exp_t e);
        exp_t         be;
        exp_t         bef;
        exp_t         sh;
        logic [127:0] t;
        logic [63:0]  q;
        logic         g;
        logic         st;
        logic [24:0]  rnd;
        logic [35:0]  w;
        be = e + 12'sd190;
        if (be >= 12'sd1)
        begin
            sh  = 12'sd40;
            bef = be;
        end
        else
        begin
            sh  = 12'sd41 - be;
            bef = 12'sd1;
        end
        t = {m, 64'd0} >> sh[6:0];
        if (sh >= 12'sd65)
        begin
            q  = 64'd0;
            g  = 1'b0;
            st = 1'b0;
        end
        else
        begin
            q  = t[127:64];
            g  = t[63];
            st = |t[62:0];
        end
        rnd = 25'(q) + {24'd0, g & (st | q[0])};
        w   = (36'($unsigned(bef - 12'sd1)) << 23) + 36'(rnd);
        if (w >= (36'd255 << 23))
        begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, w[30:0]};
    endfunction

    function automatic logic [7:0] round_mag(input logic [31:0] b, input logic [7:0] cap);
        logic [7:0]  ex;
        logic [23:0] m;
        exp_t        e;
        logic [4:0]  sh;
        logic [24:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        ex = b[30:23];
        m  = (ex == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
        e  = (ex == 8'd0) ? -12'sd149 : $signed({4'd0, ex}) - 12'sd150;
        sh = 5'(12'sd0 - e);
        q  = 25'(m >> sh);
        rem  = m & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        if (is_inf(b))
        begin
            return cap;
        end
        if (m == 24'd0)
        begin
            return 8'd0;
        end
        if (e >= 12'sd0)
        begin
            return cap;
        end
        if (e <= -12'sd25)
        begin
            return 8'd0;
        end
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 25'd1;
        end
        return (q > 25'(cap)) ? cap : q[7:0];
    endfunction

    function automatic logic [31:0] convert_out(input logic [31:0] f, input fmt_t fmt);
        logic [31:0] rsum;
        logic [7:0]  mag;
        rsum = f + 32'h0000_7FFF + {31'd0, f[16]};
        mag  = 8'd0;
        case (fmt)
            FMT_U8:
            begin
                if (is_nan(f) || f[31])
                begin
                    return 32'd0;
                end
                return {24'd0, round_mag(f, 8'd255)};
            end
            FMT_S8:
            begin
                if (is_nan(f))
                begin
                    return 32'h0000_0080;
                end
                if (f[31])
                begin
                    mag = round_mag(f, 8'd128);
                    return {24'd0, 8'd0 - mag};
                end
                return {24'd0, round_mag(f, 8'd127)};
            end
            FMT_FP32:
            begin
                return f;
            end
            FMT_BF16:
            begin
                if (is_nan(f))
                begin
                    return {16'd0, f[31:16] | 16'h0040};
                end
                if (f[30:23] == 8'd0)
                begin
                    return {16'd0, f[31], 15'd0};
                end
                return {16'd0, rsum[31:16]};
            end
            default:
            begin
                return f;
            end
        endcase
    endfunction

endpackage

// ----- hdl/mtrq_mac_cell.sv -----
module mtrq_mac_cell
    import mtrq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        acc_en,
    input  logic        shift_en,
    input  logic [7:0]  a_byte,
    input  logic [7:0]  b_byte,
    input  logic [31:0] acc_in,
    output logic [31:0] acc_out
);

    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;
    logic signed [16:0] prod;

    assign prod = $signed({1'b0, a_byte}) * $signed({b_byte[7], b_byte});

    always_comb
    begin
        acc_next = acc_reg;
        if (shift_en)
        begin
            acc_next = acc_in;
        end
        else if (acc_en)
        begin
            acc_next = acc_reg + {{15{prod[16]}}, prod};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 32'd0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ----- hdl/mtrq_requant.sv -----
module mtrq_requant
    import mtrq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_acc,
    input  elem_tag_t   in_tag,
    input  logic [31:0] scale,
    input  logic [31:0] offset,
    input  fmt_t        fmt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_value,
    output elem_tag_t   out_tag
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_NORM,
        ST_ROUND,
        ST_MUL,
        ST_ALIGN,
        ST_ADD,
        ST_CONV
    } state_t;

    state_t      state_reg;
    logic        fma_phase_reg;
    logic        rs_reg;
    logic [63:0] r_reg;
    exp_t        eb_reg;
    logic [63:0] m_reg;
    exp_t        e_reg;
    logic [31:0] xf_reg;
    logic [31:0] y_reg;
    logic [47:0] p_reg;
    exp_t        ep_reg;
    logic        ps_reg;
    logic        zz_reg;
    logic [63:0] big_reg;
    logic [63:0] small_reg;
    exp_t        d_reg;
    logic        bs_reg;
    logic        ss_reg;
    elem_tag_t   tag_reg;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    elem_tag_t   out_tag_reg;

    logic [31:0] mag;
    logic [5:0]  norm_lz;
    logic [31:0] rounded;
    logic        ps;
    logic        zs;
    logic        spec_hit;
    logic [31:0] spec_val;
    logic [23:0] mx;
    logic [23:0] my;
    exp_t        ex;
    exp_t        ey;
    logic [5:0]  p_lz;
    logic [5:0]  c_lz;
    logic [63:0] pn;
    logic [63:0] cn;
    exp_t        epn;
    exp_t        ezn;
    logic [63:0] small_sh;
    logic        load_out;

    assign mag     = in_acc[31] ? (32'd0 - in_acc) : in_acc;
    assign norm_lz = lzc64(r_reg);
    assign rounded = round_pack(rs_reg, m_reg, e_reg);

    assign ps = xf_reg[31] ^ scale[31];
    assign zs = offset[31];
    assign mx = (xf_reg[30:23] == 8'd0) ? {1'b0, xf_reg[22:0]} : {1'b1, xf_reg[22:0]};
    assign my = (scale[30:23] == 8'd0) ? {1'b0, scale[22:0]} : {1'b1, scale[22:0]};
    assign ex = (xf_reg[30:23] == 8'd0) ? -12'sd149
                                         : $signed({4'd0, xf_reg[30:23]}) - 12'sd150;
    assign ey = (scale[30:23] == 8'd0) ? -12'sd149
                                        : $signed({4'd0, scale[30:23]}) - 12'sd150;

    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = 32'd0;
        if (is_nan(xf_reg))
        begin
            spec_val = xf_reg | 32'h0040_0000;
        end
        else if (is_nan(scale))
        begin
            spec_val = scale | 32'h0040_0000;
        end
        else if (is_nan(offset))
        begin
            spec_val = offset | 32'h0040_0000;
        end
        else if ((is_inf(xf_reg) && is_zero(scale)) || (is_zero(xf_reg) && is_inf(scale)))
        begin
            spec_val = QNAN_DEFAULT;
        end
        else if (is_inf(xf_reg) || is_inf(scale))
        begin
            spec_val = (is_inf(offset) && zs != ps) ? QNAN_DEFAULT : {ps, 8'hFF, 23'd0};
        end
        else if (is_inf(offset))
        begin
            spec_val = offset;
        end
        else if (is_zero(xf_reg) || is_zero(scale))
        begin
            spec_val = is_zero(offset) ? {ps & zs, 31'd0} : offset;
        end
        else
        begin
            spec_hit = 1'b0;
        end
    end

    assign p_lz = lzc64({16'd0, p_reg});
    assign c_lz = lzc64({40'd0, (offset[30:23] == 8'd0) ? 1'b0 : 1'b1, offset[22:0]});
    assign pn   = {16'd0, p_reg} << (p_lz - 6'd2);
    assign cn   = {40'd0, (offset[30:23] == 8'd0) ? 1'b0 : 1'b1, offset[22:0]} << (c_lz - 6'd2);
    assign epn  = ep_reg - 12'(p_lz - 6'd2);
    assign ezn  = ((offset[30:23] == 8'd0) ? -12'sd149
                                            : $signed({4'd0, offset[30:23]}) - 12'sd150)
                  - 12'(c_lz - 6'd2);

    assign small_sh = shift_sticky(small_reg, d_reg);
    assign load_out = (state_reg == ST_CONV) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        tag_reg       <= in_tag;
                        fma_phase_reg <= 1'b0;
                        rs_reg        <= in_acc[31];
                        r_reg         <= {32'd0, mag};
                        eb_reg        <= 12'sd0;
                        xf_reg        <= 32'd0;
                        state_reg     <= (mag == 32'd0) ? ST_MUL : ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (r_reg == 64'd0)
                    begin
                        y_reg     <= 32'd0;
                        state_reg <= ST_CONV;
                    end
                    else
                    begin
                        m_reg     <= r_reg << norm_lz;
                        e_reg     <= eb_reg - 12'(norm_lz);
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    if (fma_phase_reg)
                    begin
                        y_reg     <= rounded;
                        state_reg <= ST_CONV;
                    end
                    else
                    begin
                        xf_reg    <= rounded;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (spec_hit)
                    begin
                        y_reg     <= spec_val;
                        state_reg <= ST_CONV;
                    end
                    else
                    begin
                        p_reg     <= mx * my;
                        ep_reg    <= ex + ey;
                        ps_reg    <= ps;
                        zz_reg    <= is_zero(offset);
                        state_reg <= ST_ALIGN;
                    end
                end
                ST_ALIGN:
                begin
                    if (zz_reg || epn >= ezn)
                    begin
                        big_reg   <= pn;
                        bs_reg    <= ps_reg;
                        eb_reg    <= epn;
                        small_reg <= zz_reg ? 64'd0 : cn;
                        ss_reg    <= zs;
                        d_reg     <= zz_reg ? 12'sd0 : epn - ezn;
                    end
                    else
                    begin
                        big_reg   <= cn;
                        bs_reg    <= zs;
                        eb_reg    <= ezn;
                        small_reg <= pn;
                        ss_reg    <= ps_reg;
                        d_reg     <= ezn - epn;
                    end
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    fma_phase_reg <= 1'b1;
                    if (bs_reg == ss_reg)
                    begin
                        r_reg  <= big_reg + small_sh;
                        rs_reg <= bs_reg;
                    end
                    else if (big_reg >= small_sh)
                    begin
                        r_reg  <= big_reg - small_sh;
                        rs_reg <= bs_reg;
                    end
                    else
                    begin
                        r_reg  <= small_sh - big_reg;
                        rs_reg <= ss_reg;
                    end
                    state_reg <= ST_NORM;
                end
                ST_CONV:
                begin
                    if (load_out)
                    begin
                        out_value_reg <= convert_out(y_reg, fmt);
                        out_tag_reg   <= tag_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_tag   = out_tag_reg;

endmodule

// ----- hdl/int8_matmul_tile_requantize_core.sv -----
// Output-stationary u8 x s8 matrix-multiply tile with fp32 requantisation.
// Input stream: tuser = operation (0 accumulate, 1 flush), tdata = a_column
// in bits 31..0 and b_row in bits 63..32. Output stream: one transfer per tile
// element on a flush, row-major, tlast on the final element.
// Accumulate items are taken one per cycle while no flush is in progress; the
// outer product lands in the cell chain at the accepting edge. A flush shifts
// the accumulators out of the chain head one at a time into the requantiser
// and zeroes the chain behind them; no input is taken until every element
// has entered the requantiser. Each element passes its steps in order: accept,
// int-to-fp32 normalise and round, multiply, align, add, normalise and round
// again, convert; a zero accumulator goes from accept straight to multiply and
// then convert, and a special operand goes from multiply to convert. The
// requantiser takes one element at a time and no new one until the last has
// left convert; both normalise/round passes use the same shared step.
// Configuration writes (scale, offset, format) are taken at once; write them
// only while the block is idle. Reset zeroes the accumulators and loads a
// scale of 1.0, offset 0 and u8 format. A stalled receiver holds the result
// in the output register and stalls the requantiser behind it.
module int8_matmul_tile_requantize_core
    import mtrq_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // a_column, b_row
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value, row, col, zero fill
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ELEMS = TILE_ROWS * TILE_COLS;
    localparam int CW    = $clog2(ELEMS + 1);
    localparam int RW    = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int KW    = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

    logic [31:0]   scale_reg;
    logic [31:0]   offset_reg;
    fmt_t          fmt_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] row_reg;
    logic [KW-1:0] col_reg;

    logic          acc_en;
    logic          shift_en;
    logic          req_ready;
    elem_tag_t     req_tag;
    elem_tag_t     res_tag;
    logic [31:0]   res_value;
    logic [31:0]   chain [ELEMS+1];

    assign s_axis_tready = cnt_reg == CW'(0);
    assign acc_en        = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
    assign shift_en      = (cnt_reg != CW'(0)) && req_ready;
    assign chain[ELEMS]  = 32'd0;

    for (genvar i = 0; i < ELEMS; i++)
    begin : g_cell
        localparam int R = i / TILE_COLS;
        localparam int C = i % TILE_COLS;
        logic [7:0] a_byte;
        logic [7:0] b_byte;
        if (R < 4)
        begin : g_a
            assign a_byte = s_axis_tdata[8*R +: 8];
        end
        else
        begin : g_az
            assign a_byte = 8'd0;
        end
        if (C < 4)
        begin : g_b
            assign b_byte = s_axis_tdata[32 + 8*C +: 8];
        end
        else
        begin : g_bz
            assign b_byte = 8'd0;
        end
        mtrq_mac_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .acc_en   (acc_en),
            .shift_en (shift_en),
            .a_byte   (a_byte),
            .b_byte   (b_byte),
            .acc_in   (chain[i+1]),
            .acc_out  (chain[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            offset_reg <= 32'd0;
            fmt_reg    <= FMT_U8;
            cnt_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCALE:  scale_reg  <= cfg_data;
                    REG_OFFSET: offset_reg <= cfg_data;
                    REG_FORMAT: fmt_reg    <= fmt_t'(cfg_data[1:0]);
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
            begin
                cnt_reg <= CW'(ELEMS);
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (shift_en)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (col_reg == KW'(TILE_COLS - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + KW'(1);
                end
            end
        end
    end

    assign req_tag.row  = 2'(row_reg);
    assign req_tag.col  = 2'(col_reg);
    assign req_tag.last = cnt_reg == CW'(1);

    mtrq_requant u_requant
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_reg != CW'(0)),
        .in_ready  (req_ready),
        .in_acc    (chain[0]),
        .in_tag    (req_tag),
        .scale     (scale_reg),
        .offset    (offset_reg),
        .fmt       (fmt_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (res_value),
        .out_tag   (res_tag)
    );

    assign m_axis_tdata = {4'd0, res_tag.col, res_tag.row, res_value};
    assign m_axis_tlast = res_tag.last;

endmodule
